// File: src/tvz_pkg.sv
// ----------------------------------------------------------------------------
// tvz_pkg: shared constants for the TV restoration z-update pipeline
// Data format, register indexes, fidelity mode codes and saturation helper.
// ----------------------------------------------------------------------------
`default_nettype none

package tvz_pkg;

    localparam int D_W   = 32;            // data word, signed Q16.16
    localparam int F_B   = 16;            // fraction bits
    localparam int W_W   = 31;            // weight registers, unsigned Q15.16
    localparam int T_W   = D_W + 2;       // t = Ku + z - zt
    localparam int SAT_W = D_W + 4;       // headroom before saturation
    localparam int IDX_W = 2;

    typedef logic signed [D_W-1:0] t_data;
    typedef logic [1:0]            t_mode;

    localparam t_mode MODE_L1  = 2'd0;
    localparam t_mode MODE_L2  = 2'd1;
    localparam t_mode MODE_PSN = 2'd2;

    localparam logic [IDX_W-1:0] CFG_MODE   = 2'd0;
    localparam logic [IDX_W-1:0] CFG_LOCAL  = 2'd1;
    localparam logic [IDX_W-1:0] CFG_LAMBDA = 2'd2;
    localparam logic [IDX_W-1:0] CFG_GAMMA  = 2'd3;

    localparam logic [W_W-1:0] WEIGHT_ONE = W_W'(65536);
    localparam logic [W_W-1:0] WEIGHT_MAX = '1;

    localparam logic signed [SAT_W-1:0] SAT_HI =
        {{(SAT_W-D_W+1){1'b0}}, {(D_W-1){1'b1}}};
    localparam logic signed [SAT_W-1:0] SAT_LO =
        {{(SAT_W-D_W+1){1'b1}}, {(D_W-1){1'b0}}};

    function automatic t_data sat_d(input logic signed [SAT_W-1:0] v);
        t_data r;
        if (v > SAT_HI) begin
            r = SAT_HI[D_W-1:0];
        end else if (v < SAT_LO) begin
            r = SAT_LO[D_W-1:0];
        end else begin
            r = v[D_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: src/tvz_div_pipe.sv
// ----------------------------------------------------------------------------
// tvz_div_pipe: pipelined restoring divider
// One quotient bit per stage. Caller guarantees num >> QUO_W < den.
// ----------------------------------------------------------------------------
`default_nettype none

module tvz_div_pipe #(
    parameter int DEN_W = 31,
    parameter int QUO_W = 31
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [DEN_W+QUO_W-1:0] i_num,
    input  logic [DEN_W-1:0]       i_den,
    output logic [QUO_W-1:0]       o_quo
);

    localparam int A_W = DEN_W + QUO_W;

    // {partial remainder, remaining dividend bits / quotient bits}
    logic [A_W-1:0]   r_a [QUO_W];
    logic [DEN_W-1:0] r_d [QUO_W-1];

    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        logic [A_W-1:0]   w_a;
        logic [DEN_W-1:0] w_d;
        logic [DEN_W:0]   w_top;
        logic [DEN_W:0]   w_dif;
        logic [A_W-1:0]   n_a;

        if (k == 0) begin : g_first
            assign w_a = i_num;
            assign w_d = i_den;
        end else begin : g_next
            assign w_a = r_a[k-1];
            assign w_d = r_d[k-1];
        end

        assign w_top = w_a[A_W-1:QUO_W-1];
        assign w_dif = w_top - {1'b0, w_d};
        assign n_a   = (w_top >= {1'b0, w_d}) ?
                       {w_dif[DEN_W-1:0], w_a[QUO_W-2:0], 1'b1} :
                       {w_top[DEN_W-1:0], w_a[QUO_W-2:0], 1'b0};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_a[k] <= n_a;
            end
        end

        if (k < QUO_W - 1) begin : g_den
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_d[k] <= w_d;
                end
            end
        end
    end

    assign o_quo = r_a[QUO_W-1][QUO_W-1:0];

endmodule

`default_nettype wire

// File: src/tvz_sqrt_pipe.sv
// ----------------------------------------------------------------------------
// tvz_sqrt_pipe: pipelined integer square root
// Digit-by-digit, one root bit per stage; o_root = floor(sqrt(i_rad)).
// ----------------------------------------------------------------------------
`default_nettype none

module tvz_sqrt_pipe #(
    parameter int ROOT_W = 32
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [2*ROOT_W-1:0]   i_rad,
    output logic [ROOT_W-1:0]     o_root
);

    localparam int X_W   = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 2;

    logic [X_W-1:0]    r_x    [ROOT_W-1];
    logic [REM_W-1:0]  r_rem  [ROOT_W-1];
    logic [ROOT_W-1:0] r_root [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic [X_W-1:0]    w_x;
        logic [REM_W-1:0]  w_rem;
        logic [ROOT_W-1:0] w_root;
        logic [REM_W+1:0]  w_cur;
        logic [REM_W+1:0]  w_trial;
        logic [REM_W+1:0]  w_dif;
        logic              w_ge;

        if (k == 0) begin : g_first
            assign w_x    = i_rad;
            assign w_rem  = '0;
            assign w_root = '0;
        end else begin : g_next
            assign w_x    = r_x[k-1];
            assign w_rem  = r_rem[k-1];
            assign w_root = r_root[k-1];
        end

        assign w_cur   = {w_rem, w_x[X_W-1:X_W-2]};
        assign w_trial = {2'b00, w_root, 2'b01};
        assign w_dif   = w_cur - w_trial;
        assign w_ge    = (w_cur >= w_trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_root[k] <= {w_root[ROOT_W-2:0], w_ge};
            end
        end

        if (k < ROOT_W - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_x[k]   <= {w_x[X_W-3:0], 2'b00};
                    r_rem[k] <= w_ge ? w_dif[REM_W-1:0] : w_cur[REM_W-1:0];
                end
            end
        end
    end

    assign o_root = r_root[ROOT_W-1];

endmodule

`default_nettype wire

// File: src/tv_restoration_z_update_top.sv
// ----------------------------------------------------------------------------
// tv_restoration_z_update_top: per-pixel z-subproblem update
// Split Bregman z update for TV restoration (L1, L2 and Poisson fidelity).
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel: i_valid / o_stall. A request (Ku, f, z, z-tilde, local
//    weight) is taken at a clock edge with i_valid high and o_stall low.
//  - Output channel: o_valid / i_stall. One result (z_new, ztilde_new) per
//    request, in order. The result sits in the output register until taken.
//  - Throughput: one request per cycle, sustained while no result waits stalled.
//  - Depth: 71 register stages, set by the two pipelined dividers:
//    31 stages for beta = lambda/gamma2 and 34 stages for the L2 quotient;
//    the 32-stage square root runs beside the second divider.
//  - Stall: the whole pipeline freezes while a result waits with i_stall
//    high; o_stall follows that condition combinationally.
//  - Reset (synchronous, active low): empties the pipeline and loads the
//    register defaults (L1, constant lambda, lambda = gamma2 = 1.0).
//  - Config port: i_cfg_we / i_cfg_idx / i_cfg_data, written while idle.
//    Mode 3 acts as L1; gamma2 of zero acts as the smallest step.
// ----------------------------------------------------------------------------
`default_nettype none

module tv_restoration_z_update_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [tvz_pkg::IDX_W-1:0]         i_cfg_idx,
    input  logic [tvz_pkg::W_W-1:0]           i_cfg_data,
    // request channel
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic signed [tvz_pkg::D_W-1:0]    i_blurred_u,
    input  logic signed [tvz_pkg::D_W-1:0]    i_observed,
    input  logic signed [tvz_pkg::D_W-1:0]    i_z_old,
    input  logic signed [tvz_pkg::D_W-1:0]    i_ztilde_old,
    input  logic [tvz_pkg::W_W-1:0]           i_local_lambda,
    // result channel
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [tvz_pkg::D_W-1:0]    o_z_new,
    output logic signed [tvz_pkg::D_W-1:0]    o_ztilde_new
);

    import tvz_pkg::*;

    // pipeline geometry
    localparam int BD_Q   = W_W;             // beta quotient bits
    localparam int BD_A   = W_W + BD_Q;      // beta divider word
    localparam int ZD_Q   = D_W + 2;         // |L2 quotient| < 2^33
    localparam int ZD_D   = D_W;             // 2^16 + beta
    localparam int ZD_A   = ZD_D + ZD_Q;
    localparam int SQ_LAT = D_W;
    localparam int SQ_PAD = ZD_Q - SQ_LAT;
    localparam int P_W    = 2 * D_W;         // products
    localparam int BF_W   = 2 * D_W - 1;     // beta * f
    localparam int ZL_W   = D_W + 3;         // L1 result before saturation
    localparam int SH_W   = W_W - F_B;       // beta overflow compare shift
    localparam int L_TOT  = 1 + BD_Q + 3 + ZD_Q + 2;

    // ---------------- configuration registers ----------------
    t_mode          r_mode;
    logic           r_local;
    logic [W_W-1:0] r_lambda;
    logic [W_W-1:0] r_gamma;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_L1;
            r_local  <= 1'b0;
            r_lambda <= WEIGHT_ONE;
            r_gamma  <= WEIGHT_ONE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MODE:   r_mode   <= i_cfg_data[1:0];
                CFG_LOCAL:  r_local  <= i_cfg_data[0];
                CFG_LAMBDA: r_lambda <= i_cfg_data;
                CFG_GAMMA:  r_gamma  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- flow control ----------------
    logic             adv;
    logic [L_TOT-1:0] r_vld;

    // everything moves unless the output holds a result that is stalled
    assign adv     = !(r_vld[L_TOT-1] && i_stall);
    assign o_stall = !adv;
    assign o_valid = r_vld[L_TOT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[L_TOT-2:0], i_valid};
        end
    end

    // ---------------- stage 0: input register ----------------
    logic [W_W-1:0]          lam;
    logic [W_W-1:0]          geff;
    logic                    ovf;
    logic [BD_A-1:0]         r0_num;
    logic [W_W-1:0]          r0_den;
    logic                    r0_ovf;
    logic signed [T_W-1:0]   r0_t;
    t_data                   r0_f;

    assign lam  = r_local ? i_local_lambda : r_lambda;
    assign geff = (r_gamma == '0) ? W_W'(1) : r_gamma;
    // beta >= 2^31 exactly when lambda >= gamma2 * 2^15
    assign ovf  = ({{SH_W{1'b0}}, lam} >= {geff, {SH_W{1'b0}}});

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r0_num <= BD_A'({lam, {F_B{1'b0}}});
            r0_den <= geff;
            r0_ovf <= ovf;
            r0_t   <= T_W'(i_blurred_u) + T_W'(i_z_old) - T_W'(i_ztilde_old);
            r0_f   <= i_observed;
        end
    end

    // ---------------- beta divider, with side band ----------------
    logic [BD_Q-1:0]        bq;
    logic signed [T_W-1:0]  r_bt  [BD_Q];
    t_data                  r_bff [BD_Q];
    logic                   r_bo  [BD_Q];

    tvz_div_pipe #(
        .DEN_W (W_W),
        .QUO_W (BD_Q)
    ) u_beta_div (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_num (r0_num),
        .i_den (r0_den),
        .o_quo (bq)
    );

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_bt[0]  <= r0_t;
            r_bff[0] <= r0_f;
            r_bo[0]  <= r0_ovf;
            for (int k = 1; k < BD_Q; k++) begin
                r_bt[k]  <= r_bt[k-1];
                r_bff[k] <= r_bff[k-1];
                r_bo[k]  <= r_bo[k-1];
            end
        end
    end

    // ---------------- M1: beta, beta*f, Poisson h, L1 result ----------------
    logic [W_W-1:0]          beta;
    logic signed [D_W-1:0]   beta_s;
    logic signed [P_W-1:0]   m1_prod;
    logic signed [SAT_W-1:0] m1_t;
    logic signed [SAT_W-1:0] m1_f;
    logic signed [SAT_W-1:0] m1_b;
    logic signed [SAT_W-1:0] m1_tb;
    logic signed [SAT_W-1:0] m1_d;
    logic signed [SAT_W-1:0] m1_zl;

    logic [W_W-1:0]          r1_beta;
    logic signed [BF_W-1:0]  r1_bf;
    t_data                   r1_h;
    logic signed [ZL_W-1:0]  r1_zl;
    logic signed [T_W-1:0]   r1_t;

    assign beta    = r_bo[BD_Q-1] ? WEIGHT_MAX : bq;
    assign beta_s  = $signed({1'b0, beta});
    assign m1_prod = P_W'(beta_s) * P_W'(r_bff[BD_Q-1]);
    assign m1_t    = SAT_W'(r_bt[BD_Q-1]);
    assign m1_f    = SAT_W'(r_bff[BD_Q-1]);
    assign m1_b    = SAT_W'(beta_s);
    assign m1_tb   = (m1_t - m1_b) >>> 1;     // floor((t - beta) / 2)
    assign m1_d    = m1_t - m1_f;

    // L1 soft threshold
    always_comb begin
        if (m1_d > m1_b) begin
            m1_zl = m1_t - m1_b;
        end else if (m1_d < -m1_b) begin
            m1_zl = m1_t + m1_b;
        end else begin
            m1_zl = m1_f;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_beta <= beta;
            r1_bf   <= m1_prod[BF_W-1:0];
            r1_h    <= sat_d(m1_tb);
            r1_zl   <= m1_zl[ZL_W-1:0];
            r1_t    <= r_bt[BD_Q-1];
        end
    end

    // ---------------- M2: h^2, L2 numerator and divisor ----------------
    logic [D_W-1:0]          m2_ah;
    logic [P_W-1:0]          m2_sq;

    logic [BF_W-1:0]         r2_h2;
    logic signed [P_W-1:0]   r2_num;
    logic [ZD_D-1:0]         r2_den;
    logic signed [BF_W-1:0]  r2_bf;
    t_data                   r2_h;
    logic signed [ZL_W-1:0]  r2_zl;
    logic signed [T_W-1:0]   r2_t;

    assign m2_ah = r1_h[D_W-1] ? (~r1_h + D_W'(1)) : r1_h;
    assign m2_sq = P_W'(m2_ah) * P_W'(m2_ah);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_h2  <= m2_sq[BF_W-1:0];
            r2_num <= (P_W'(r1_t) <<< F_B) + P_W'(r1_bf);
            r2_den <= ZD_D'(r1_beta) + (ZD_D'(1) << F_B);
            r2_bf  <= r1_bf;
            r2_h   <= r1_h;
            r2_zl  <= r1_zl;
            r2_t   <= r1_t;
        end
    end

    // ---------------- M3: radicand, |numerator| ----------------
    logic signed [P_W:0]     m3_rs;
    logic [P_W-1:0]          r3_rad;
    logic [P_W-1:0]          r3_nabs;
    logic                    r3_nneg;
    logic [ZD_D-1:0]         r3_den;
    t_data                   r3_h;
    logic signed [ZL_W-1:0]  r3_zl;
    logic signed [T_W-1:0]   r3_t;

    assign m3_rs = $signed({2'b00, r2_h2}) + (P_W+1)'(r2_bf);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r3_rad  <= m3_rs[P_W] ? '0 : m3_rs[P_W-1:0];   // negative radicand -> 0
            r3_nabs <= r2_num[P_W-1] ? P_W'(-r2_num) : P_W'(r2_num);
            r3_nneg <= r2_num[P_W-1];
            r3_den  <= r2_den;
            r3_h    <= r2_h;
            r3_zl   <= r2_zl;
            r3_t    <= r2_t;
        end
    end

    // ---------------- L2 divider and square root, in parallel ----------------
    logic [ZD_Q-1:0]         zq;
    logic [D_W-1:0]          sq;
    logic [D_W-1:0]          r_sq_pad [SQ_PAD];
    t_data                   r_zh  [ZD_Q];
    logic signed [ZL_W-1:0]  r_zl  [ZD_Q];
    logic signed [T_W-1:0]   r_zt  [ZD_Q];
    logic                    r_zng [ZD_Q];

    tvz_div_pipe #(
        .DEN_W (ZD_D),
        .QUO_W (ZD_Q)
    ) u_l2_div (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_num (ZD_A'(r3_nabs)),
        .i_den (r3_den),
        .o_quo (zq)
    );

    tvz_sqrt_pipe #(
        .ROOT_W (D_W)
    ) u_sqrt (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_rad  (r3_rad),
        .o_root (sq)
    );

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sq_pad[0] <= sq;
            for (int k = 1; k < SQ_PAD; k++) begin
                r_sq_pad[k] <= r_sq_pad[k-1];
            end
            r_zh[0]  <= r3_h;
            r_zl[0]  <= r3_zl;
            r_zt[0]  <= r3_t;
            r_zng[0] <= r3_nneg;
            for (int k = 1; k < ZD_Q; k++) begin
                r_zh[k]  <= r_zh[k-1];
                r_zl[k]  <= r_zl[k-1];
                r_zt[k]  <= r_zt[k-1];
                r_zng[k] <= r_zng[k-1];
            end
        end
    end

    // ---------------- F1: mode select, saturate z ----------------
    logic signed [SAT_W-1:0] f1_q;
    logic signed [SAT_W-1:0] f1_l2;
    logic signed [SAT_W-1:0] f1_ps;
    logic signed [SAT_W-1:0] f1_z;
    t_data                   r5_zn;
    logic signed [T_W-1:0]   r5_t;

    assign f1_q  = $signed(SAT_W'(zq));
    assign f1_l2 = r_zng[ZD_Q-1] ? -f1_q : f1_q;     // truncate toward zero
    assign f1_ps = SAT_W'(r_zh[ZD_Q-1]) + $signed(SAT_W'(r_sq_pad[SQ_PAD-1]));

    always_comb begin
        case (r_mode)
            MODE_L2:  f1_z = f1_l2;
            MODE_PSN: f1_z = f1_ps;
            default:  f1_z = SAT_W'(r_zl[ZD_Q-1]);   // L1 and reserved code
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r5_zn <= sat_d(f1_z);
            r5_t  <= r_zt[ZD_Q-1];
        end
    end

    // ---------------- output register: z-tilde = zt + 2 z_new - z - Ku ----------------
    logic signed [SAT_W-1:0] o_zt_sum;
    t_data                   r_o_z;
    t_data                   r_o_zt;

    assign o_zt_sum = (SAT_W'(r5_zn) <<< 1) - SAT_W'(r5_t);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_o_z  <= r5_zn;
            r_o_zt <= sat_d(o_zt_sum);
        end
    end

    assign o_z_new      = r_o_z;
    assign o_ztilde_new = r_o_zt;

endmodule

`default_nettype wire

// File: src/tvz_chk.sv
// ----------------------------------------------------------------------------
// tvz_chk: port-level checks for tv_restoration_z_update_top
// Result channel hold rules, stall source and reset behavior.
// ----------------------------------------------------------------------------
`default_nettype none

module tvz_chk (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              o_stall,
    input  logic                              o_valid,
    input  logic                              i_stall,
    input  logic signed [tvz_pkg::D_W-1:0]    o_z_new,
    input  logic signed [tvz_pkg::D_W-1:0]    o_ztilde_new
);

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its value
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_z_new) && $stable(o_ztilde_new))
        else $error("result changed while stalled");

    // back-pressure only comes from a waiting result
    a_stall_src: assert property (@(posedge i_clk)
        o_stall |-> o_valid && i_stall)
        else $error("request side stalled without a stalled result");

    // reset empties the pipeline
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result offered right after reset");

endmodule

bind tv_restoration_z_update_top tvz_chk u_tvz_chk (.*);

`default_nettype wire
